[hdl/modexp_pkg.sv]
package modexp_pkg;

   localparam int MOD_WIDTH       = 32;
   localparam int EXP_WIDTH       = 64;
   localparam int BASE_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam int STEP_CNT_WIDTH  = $clog2(BASE_WIDTH);
   localparam int BITS_LEFT_WIDTH = $clog2(EXP_WIDTH);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODULUS  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXPONENT = CSR_INDEX_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_NORM,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

endpackage

[hdl/modular_exponentiation.sv]
// Modular exponentiation: each base transfer returns base^exponent mod modulus, computed
// left to right by square-and-multiply on a single shift-add-reduce modular multiplier that
// takes one multiplier bit per cycle. The base is reduced first, the exponent is then
// normalized one bit per cycle to drop its leading zeros and its top set bit, and every
// remaining exponent bit costs one square plus one multiply when the bit is set; the done
// state then moves the answer to the output register once that register is free. An
// exponent of zero answers 1 mod n after the reduction, and a modulus of zero answers 0 at
// once. The input is stalled while an item is in work; the next base is taken as soon as
// the finished result sits in the output register, even if the consumer still stalls it.
// Modulus and exponent are written through the csr port, which is ready only while the
// block is idle with no result pending and no base offered; unknown register indexes are
// ignored.
module modular_exponentiation (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [modexp_pkg::BASE_WIDTH-1:0]      req_base,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [modexp_pkg::BASE_WIDTH-1:0]      rsp_result,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [modexp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int MW = modexp_pkg::MOD_WIDTH;
   localparam int EW = modexp_pkg::EXP_WIDTH;
   localparam int BW = modexp_pkg::BASE_WIDTH;
   localparam int CW = modexp_pkg::STEP_CNT_WIDTH;
   localparam int LW = modexp_pkg::BITS_LEFT_WIDTH;

   // configuration registers
   logic [MW-1:0] mod_ff, mod_in;
   logic [EW-1:0] exp_cfg_ff, exp_cfg_in;

   // sequencer
   modexp_pkg::state_type state_ff, state_in;

   // exponent scan
   logic [EW-1:0] exp_ff, exp_in;
   logic [LW-1:0] bits_left_ff, bits_left_in;

   // working values
   logic [MW-1:0] acc_ff, acc_in;
   logic [MW-1:0] rbase_ff, rbase_in;

   // shared modular multiplier: prod = opa * opm mod n, one bit of opa per cycle
   logic [BW-1:0] opa_ff, opa_in;
   logic [MW-1:0] opm_ff, opm_in;
   logic [MW-1:0] prod_ff, prod_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_result_ff, rsp_result_in;

   // multiplier datapath
   logic [MW:0]   n_ext;
   logic [MW:0]   dbl;
   logic [MW-1:0] dbl_red;
   logic [MW-1:0] addend;
   logic [MW:0]   sum;
   logic [MW:0]   sum_sub;
   logic [MW:0]   dbl_sub;
   logic [MW-1:0] prod_next;
   logic          step_last;

   logic req_xfer;
   logic csr_xfer;
   logic rsp_free;

   assign req_stall  = (state_ff != modexp_pkg::ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   // hold off register writes while a base is offered so a transfer never mixes settings
   assign csr_ready  = (state_ff == modexp_pkg::ST_IDLE) && !rsp_valid_ff && !req_valid;
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // double the partial remainder, reduce, add the selected addend, reduce again;
   // both stay below 2n so one subtract each is enough
   assign n_ext     = {1'b0, mod_ff};
   assign dbl       = {prod_ff, 1'b0};
   assign dbl_sub   = dbl - n_ext;
   assign dbl_red   = (dbl >= n_ext) ? dbl_sub[MW-1:0] : dbl[MW-1:0];
   assign addend    = opa_ff[BW-1] ? opm_ff : '0;
   assign sum       = {1'b0, dbl_red} + {1'b0, addend};
   assign sum_sub   = sum - n_ext;
   assign prod_next = (sum >= n_ext) ? sum_sub[MW-1:0] : sum[MW-1:0];
   assign step_last = (cnt_ff == CW'(BW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         mod_ff       <= MW'(1);
         exp_cfg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         exp_cfg_ff   <= exp_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff        <= exp_in;
      bits_left_ff  <= bits_left_in;
      acc_ff        <= acc_in;
      rbase_ff      <= rbase_in;
      opa_ff        <= opa_in;
      opm_ff        <= opm_in;
      prod_ff       <= prod_in;
      cnt_ff        <= cnt_in;
      rsp_result_ff <= rsp_result_in;
   end

   always_comb begin
      state_in      = state_ff;
      mod_in        = mod_ff;
      exp_cfg_in    = exp_cfg_ff;
      exp_in        = exp_ff;
      bits_left_in  = bits_left_ff;
      acc_in        = acc_ff;
      rbase_in      = rbase_ff;
      opa_in        = opa_ff;
      opm_in        = opm_ff;
      prod_in       = prod_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;

      // drop the result once the consumer takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_xfer) begin
         if (csr_index == modexp_pkg::REG_MODULUS) begin
            mod_in = csr_wdata[MW-1:0];
         end else if (csr_index == modexp_pkg::REG_EXPONENT) begin
            exp_cfg_in = csr_wdata[EW-1:0];
         end
      end

      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (mod_ff == '0) begin
                  acc_in   = '0;
                  rbase_in = '0;
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  // base mod n as base * 1 mod n
                  opa_in   = req_base;
                  opm_in   = MW'(1);
                  prod_in  = '0;
                  cnt_in   = '0;
                  state_in = modexp_pkg::ST_REDUCE;
               end
            end
         end

         modexp_pkg::ST_REDUCE: begin
            prod_in = prod_next;
            opa_in  = opa_ff << 1;
            cnt_in  = cnt_ff + CW'(1);
            if (step_last) begin
               rbase_in = prod_next;
               if (exp_cfg_ff == '0) begin
                  acc_in   = (mod_ff == MW'(1)) ? '0 : MW'(1);
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  acc_in       = prod_next;
                  exp_in       = exp_cfg_ff;
                  bits_left_in = LW'(EW - 1);
                  state_in     = modexp_pkg::ST_NORM;
               end
            end
         end

         modexp_pkg::ST_NORM: begin
            // shift out leading zeros, then the top set bit itself
            exp_in = exp_ff << 1;
            if (exp_ff[EW-1]) begin
               if (bits_left_ff == '0) begin
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  opa_in   = BW'(acc_ff);
                  opm_in   = acc_ff;
                  prod_in  = '0;
                  cnt_in   = '0;
                  state_in = modexp_pkg::ST_SQUARE;
               end
            end else begin
               bits_left_in = bits_left_ff - LW'(1);
            end
         end

         modexp_pkg::ST_SQUARE, modexp_pkg::ST_MULT: begin
            prod_in = prod_next;
            opa_in  = opa_ff << 1;
            cnt_in  = cnt_ff + CW'(1);
            if (step_last) begin
               acc_in = prod_next;
               if ((state_ff == modexp_pkg::ST_SQUARE) && exp_ff[EW-1]) begin
                  opa_in   = BW'(prod_next);
                  opm_in   = rbase_ff;
                  prod_in  = '0;
                  cnt_in   = '0;
                  state_in = modexp_pkg::ST_MULT;
               end else if (bits_left_ff == LW'(1)) begin
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  // advance to the next exponent bit
                  exp_in       = exp_ff << 1;
                  bits_left_in = bits_left_ff - LW'(1);
                  opa_in       = BW'(prod_next);
                  opm_in       = prod_next;
                  prod_in      = '0;
                  cnt_in       = '0;
                  state_in     = modexp_pkg::ST_SQUARE;
               end
            end
         end

         modexp_pkg::ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = BW'(acc_ff);
               state_in      = modexp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // the partial remainder of the multiplier never reaches the modulus
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == modexp_pkg::ST_SQUARE) || (state_ff == modexp_pkg::ST_MULT))
         |-> (prod_ff < mod_ff))
      else $error("multiplier remainder not below modulus");

   // an accepted base puts the sequencer to work
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != modexp_pkg::ST_IDLE))
      else $error("sequencer idle after base transfer");

   // a result only appears on leaving the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == modexp_pkg::ST_DONE))
      else $error("result raised outside done state");

   // the done state never overwrites a result still held by the consumer
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == modexp_pkg::ST_DONE) && rsp_valid_ff && rsp_stall)
         |=> (state_ff == modexp_pkg::ST_DONE) && $stable(rsp_result_ff))
      else $error("pending result overwritten");

endmodule

[tb/modular_exponentiation_test.sv]
module modular_exponentiation_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MOD_WIDTH       = modexp_pkg::MOD_WIDTH;
   localparam int EXP_WIDTH       = modexp_pkg::EXP_WIDTH;
   localparam int BASE_WIDTH      = modexp_pkg::BASE_WIDTH;
   localparam int CSR_INDEX_WIDTH = modexp_pkg::CSR_INDEX_WIDTH;
   localparam int CSR_DATA_WIDTH  = modexp_pkg::CSR_DATA_WIDTH;

   // Guard against a hung block. The limit sits well above the slowest legal
   // run here, even with every item at a full 64-bit exponent.
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;
   // Wait this long after the last result to catch any stray transfer.
   localparam int unsigned SETTLE_CYCLES = 200;

   typedef struct {
      logic [BASE_WIDTH-1:0] base;
      logic [BASE_WIDTH-1:0] power;
   } power_entry_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BASE_WIDTH-1:0]      req_base = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [BASE_WIDTH-1:0]      rsp_result;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Register copies, kept in step with every csr transfer.
   logic [MOD_WIDTH-1:0]       cfg_modulus = MOD_WIDTH'(1);
   logic [EXP_WIDTH-1:0]       cfg_exponent = '0;

   logic [BASE_WIDTH-1:0]      base_backlog[$];     // bases waiting for the driver
   power_entry_type            predicted_powers[$]; // one per accepted base, oldest first
   int unsigned                results_owed = 0;    // bases queued but not yet answered
   int unsigned                send_idle_pct = 0;
   int unsigned                recv_idle_pct = 0;
   int unsigned                fault_count = 0;
   int unsigned                bases_checked = 0;
   int unsigned                register_writes = 0;
   longint unsigned            cycle_count = 0;

   modular_exponentiation dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_base   (req_base),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Left-to-right square-and-multiply. Reduce the base first, seed the
   // running power with it, then walk from the bit below the top set bit
   // of the exponent down to bit 0. Operands stay below 2^32, so every
   // product fits in 64 bits.
   function automatic logic [BASE_WIDTH-1:0] power_mod(input logic [BASE_WIDTH-1:0] base,
                                                       input logic [MOD_WIDTH-1:0]  n,
                                                       input logic [EXP_WIDTH-1:0]  e);
      logic [63:0] acc;
      logic [63:0] b;
      int          msb;
      // A zero modulus skips the division and answers zero.
      if (n == '0)
         return '0;
      b = 64'(base) % 64'(n);
      // Zero exponent: 1 mod n, which is zero for a modulus of one.
      if (e == '0)
         return (n == MOD_WIDTH'(1)) ? '0 : BASE_WIDTH'(1);
      msb = EXP_WIDTH - 1;
      while (!e[msb])
         msb--;
      acc = b;
      for (int i = msb - 1; i >= 0; i--) begin
         acc = (acc * acc) % 64'(n);
         if (e[i])
            acc = (acc * b) % 64'(n);
      end
      return acc[BASE_WIDTH-1:0];
   endfunction

   // Driver: predict each base on its transfer, hold a stalled base, and
   // otherwise present the next pending base unless this cycle idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_powers.push_back('{base: req_base,
                                         power: power_mod(req_base, cfg_modulus,
                                                          cfg_exponent)});
         end
         if (req_valid && req_stall) begin
            // hold valid and payload until the block takes them
         end else if (base_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_base  <= base_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction,
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_powers.size() == 0) begin
               $display("%0t: result %h arrived with no base outstanding", $time, rsp_result);
               fault_count++;
            end else begin
               power_entry_type want;
               want = predicted_powers.pop_front();
               if (rsp_result !== want.power) begin
                  $display("%0t: result mismatch for base %h: expected %h, actual %h",
                           $time, want.base, want.power, rsp_result);
                  fault_count++;
               end
               bases_checked++;
               results_owed--;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: stop a run that never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: no progress after %0d cycles, %0d results owed",
                  $time, cycle_count, results_owed);
         $display("modular_exponentiation test failed");
         $finish;
      end
   end

   // Queue one base for the driver; call only right after a falling edge.
   task automatic queue_base(input logic [BASE_WIDTH-1:0] base);
      base_backlog.push_back(base);
      results_owed++;
   endtask

   // Hold off until every owed result has been seen, leaving the block idle.
   task automatic drain;
      wait (results_owed == 0);
      @(posedge clock);
   endtask

   // Write one register through the csr port and mirror it locally.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0]  data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      // Keep only the low bits; drop writes to unknown indexes.
      case (index)
         modexp_pkg::REG_MODULUS:  cfg_modulus  = data[MOD_WIDTH-1:0];
         modexp_pkg::REG_EXPONENT: cfg_exponent = data[EXP_WIDTH-1:0];
         default: ;
      endcase
      register_writes++;
   endtask

   // One random setting: pick modulus and exponent, then run a batch of bases.
   // Most batches use exponents of at most 16 bits to keep the run short;
   // a long batch forces the top exponent bit so the scan covers all 64.
   task automatic random_phase(input int unsigned count, input bit long_exponent);
      logic [MOD_WIDTH-1:0] n;
      logic [EXP_WIDTH-1:0] e;
      int unsigned          width;
      logic [BASE_WIDTH-1:0] b;
      case ($urandom_range(0, 19))
         0:       n = '0;
         1:       n = MOD_WIDTH'(1);
         2, 3:    n = MOD_WIDTH'($urandom_range(2, 255));
         default: n = $urandom;
      endcase
      // Put junk in the upper data bits; only the low bits must stick.
      write_register(modexp_pkg::REG_MODULUS, {$urandom, n});
      if (long_exponent) begin
         e = {$urandom, $urandom} | (64'd1 << (EXP_WIDTH - 1));
      end else begin
         width = $urandom_range(0, 16);
         if (width == 0)
            e = '0;
         else
            e = ({$urandom, $urandom} & ((64'd1 << width) - 1)) | (64'd1 << (width - 1));
      end
      write_register(modexp_pkg::REG_EXPONENT, e);
      if ($urandom_range(0, 3) == 0)
         write_register(CSR_INDEX_WIDTH'($urandom_range(modexp_pkg::REG_EXPONENT + 1, 255)),
                        {$urandom, $urandom});
      @(negedge clock);
      for (int k = 0; k < count; k++) begin
         // Favor the corners around the modulus, otherwise full-range bases.
         case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = BASE_WIDTH'(1);
            2:       b = BASE_WIDTH'(cfg_modulus) - BASE_WIDTH'(1);
            3:       b = BASE_WIDTH'(cfg_modulus);
            4:       b = BASE_WIDTH'($urandom_range(0, 15));
            default: b = $urandom;
         endcase
         queue_base(b);
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: sender idles now and then, receiver mostly stalls.
      @(negedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 85;

      // Reset settings: modulus one, exponent zero, so everything is zero.
      queue_base('0);
      queue_base('1);
      drain();

      // Largest modulus with a zero exponent answers one.
      write_register(modexp_pkg::REG_MODULUS, 64'h0000_0000_FFFF_FFFF);
      @(negedge clock);
      queue_base('0);
      queue_base('1);
      queue_base(32'h1234_5678);
      drain();

      // Largest modulus and an all-ones exponent: the longest scan.
      write_register(modexp_pkg::REG_EXPONENT, '1);
      @(negedge clock);
      queue_base('0);
      queue_base(32'd1);
      queue_base(32'd2);
      queue_base(32'hFFFF_FFFE);
      queue_base('1);
      drain();

      // Wide write whose low bits are zero: a zero modulus answers zero.
      write_register(modexp_pkg::REG_MODULUS, 64'hDEAD_BEEF_0000_0000);
      @(negedge clock);
      queue_base(32'd7);
      queue_base('1);
      drain();

      // Unknown indexes must leave both registers alone.
      write_register(CSR_INDEX_WIDTH'(255), '1);
      write_register(CSR_INDEX_WIDTH'(modexp_pkg::REG_EXPONENT + 1), '0);
      // Modulus two through a wide write, exponent one: no squaring at all.
      write_register(modexp_pkg::REG_MODULUS, 64'hFFFF_FFFF_0000_0002);
      write_register(modexp_pkg::REG_EXPONENT, 64'd1);
      @(negedge clock);
      queue_base(32'd5);
      queue_base(32'd6);
      drain();

      // Modulus one with a nonzero exponent still answers zero.
      write_register(modexp_pkg::REG_MODULUS, 64'd1);
      write_register(modexp_pkg::REG_EXPONENT, 64'd3);
      @(negedge clock);
      queue_base('1);
      drain();

      // Power-of-two modulus, plain squaring.
      write_register(modexp_pkg::REG_MODULUS, 64'h0000_0000_8000_0000);
      write_register(modexp_pkg::REG_EXPONENT, 64'd2);
      @(negedge clock);
      queue_base('1);
      drain();

      // Only the top exponent bit set: 63 squarings, no multiplies.
      write_register(modexp_pkg::REG_MODULUS, 64'h0000_0000_FFFF_FFFB);
      write_register(modexp_pkg::REG_EXPONENT, 64'h8000_0000_0000_0000);
      @(negedge clock);
      queue_base(32'd2);
      queue_base(32'hFFFF_FFFA);
      queue_base(32'd3);
      drain();

      // Random part, in three idling modes: light sender gaps with heavy
      // receiver stalls, the reverse, then full speed on both sides.
      for (int mode = 0; mode < 3; mode++) begin
         @(negedge clock);
         case (mode)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int p = 0; p < 4; p++)
            random_phase(9, 1'b0);
         random_phase(3, 1'b1);
      end

      // Let any stray result show up before judging the run.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_powers.size() != 0) begin
         $display("%0t: %0d predicted results never arrived", $time, predicted_powers.size());
         fault_count += predicted_powers.size();
      end

      $display("Checked %0d bases across %0d register writes, covering zero and unit moduli,",
               bases_checked, register_writes);
      $display("zero and full 64-bit exponents, unknown indexes and three idling modes.");
      if (fault_count == 0) begin
         $display("modular_exponentiation test passed");
      end else begin
         $display("%0d failures", fault_count);
         $display("modular_exponentiation test failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/modexp_pkg.sv
hdl/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
